>>> src/lsc_pkg.sv
// Shared types and constants of the LRU sector cache directory.
package lsc_pkg;

  localparam int SlotsDefault = 128;
  localparam int SectorW      = 32;
  localparam int ActionW      = 2;
  localparam int SlotW        = 7;

  localparam logic [ActionW-1:0] ActRead  = 2'd0;
  localparam logic [ActionW-1:0] ActWrite = 2'd1;
  localparam logic [ActionW-1:0] ActDrain = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic issue;
    logic scan;
    logic decide;
    logic update;
    logic commit;
    logic respond;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic nop;
    logic drain;
    logic issue_last;
    logic out_free;
  } dpath_sts_t;

  typedef struct packed {
    logic               hit;
    logic [SlotW-1:0]   slot;
    logic               fetch_needed;
    logic               writeback_valid;
    logic [SectorW-1:0] writeback_sector;
    logic               was_empty;
  } rsp_t;

endpackage

>>> src/lsc_if.sv
// Request and response channel interfaces of the sector cache directory.
interface lsc_req_if;
  logic                             valid;
  logic                             ready;
  logic [lsc_pkg::ActionW-1:0]      action;
  logic [lsc_pkg::SectorW-1:0]      sector;

  modport source (output valid, action, sector, input ready);
  modport sink   (input valid, action, sector, output ready);
endinterface

interface lsc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [lsc_pkg::SlotW-1:0]        slot;
  logic                             fetch_needed;
  logic                             writeback_valid;
  logic [lsc_pkg::SectorW-1:0]      writeback_sector;
  logic                             was_empty;

  modport source (output valid, hit, slot, fetch_needed, writeback_valid, writeback_sector,
                  was_empty, input ready);
  modport sink   (input valid, hit, slot, fetch_needed, writeback_valid, writeback_sector,
                  was_empty, output ready);
endinterface

>>> src/lsc_ctrl.sv
// Sequencer of the directory: scan pass, decision, rank update pass, response.
module lsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  lsc_pkg::dpath_sts_t sts_i,
  output lsc_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StScan    = 3'd1;
  localparam logic [2:0] StScanEnd = 3'd2;
  localparam logic [2:0] StDecide  = 3'd3;
  localparam logic [2:0] StUpdate  = 3'd4;
  localparam logic [2:0] StUpdEnd  = 3'd5;
  localparam logic [2:0] StCommit  = 3'd6;
  localparam logic [2:0] StResp    = 3'd7;

  logic [2:0] state_q, state_d;

  assign req_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        cmd_o.capture = req_valid_i;
        if (req_valid_i) state_d = StScan;
      end
      StScan: begin
        if (sts_i.nop) begin
          state_d = StIdle;
        end else begin
          cmd_o.issue = 1'b1;
          cmd_o.scan  = 1'b1;
          if (sts_i.issue_last) state_d = StScanEnd;
        end
      end
      StScanEnd: begin
        cmd_o.scan = 1'b1;
        state_d    = StDecide;
      end
      StDecide: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.drain ? StResp : StUpdate;
      end
      StUpdate: begin
        cmd_o.issue  = 1'b1;
        cmd_o.update = 1'b1;
        if (sts_i.issue_last) state_d = StUpdEnd;
      end
      StUpdEnd: begin
        cmd_o.update = 1'b1;
        state_d      = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = StResp;
      end
      StResp: begin
        if (sts_i.out_free) begin
          cmd_o.respond = 1'b1;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/lsc_dpath.sv
// Tag and rank memories, valid bits, scan accumulators and the output register.
module lsc_dpath #(
  parameter int SLOTS = lsc_pkg::SlotsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [lsc_pkg::ActionW-1:0]  action_i,
  input  logic [lsc_pkg::SectorW-1:0]  sector_i,
  input  lsc_pkg::ctrl_cmd_t           cmd_i,
  output lsc_pkg::dpath_sts_t          sts_o,
  input  logic                         rsp_ready_i,
  output logic                         rsp_valid_o,
  output lsc_pkg::rsp_t                rsp_o
);

  localparam int IW   = $clog2(SLOTS);
  localparam int LimW = IW + 1;
  localparam logic [IW-1:0]   LastIdx  = IW'(SLOTS - 1);
  localparam logic [LimW-1:0] FullLim  = LimW'(SLOTS);

  logic [lsc_pkg::SectorW-1:0] tag_mem  [SLOTS];
  logic [IW-1:0]               rank_mem [SLOTS];
  logic [SLOTS-1:0]            valid_q;

  logic [lsc_pkg::ActionW-1:0] action_q;
  logic [lsc_pkg::SectorW-1:0] sector_q;

  logic [IW-1:0]               idx_q;
  logic                        p_vld_q;
  logic [IW-1:0]               p_idx_q;
  logic [lsc_pkg::SectorW-1:0] tag_rd_q;
  logic [IW-1:0]               rank_rd_q;

  logic                        hit_fnd_q, free_fnd_q, old_fnd_q;
  logic [IW-1:0]               hit_idx_q, free_idx_q, old_idx_q;
  logic [IW-1:0]               hit_rank_q, old_rank_q;
  logic [lsc_pkg::SectorW-1:0] old_tag_q;

  logic [IW-1:0]               s_q, s_d;
  logic [LimW-1:0]             limit_q, limit_d;
  logic                        miss_q;
  lsc_pkg::rsp_t               res_q, res_d;
  logic                        set_vld, clr_vld;

  logic                        p_valid;
  logic                        age_we;
  logic                        rank_we;
  logic [IW-1:0]               rank_wa;
  logic [IW-1:0]               rank_wd;
  logic [31:0]                 s_ext;

  logic                        rsp_valid_q;
  lsc_pkg::rsp_t               rsp_q;

  assign p_valid = valid_q[p_idx_q];

  assign sts_o.nop        = (action_q != lsc_pkg::ActRead) && (action_q != lsc_pkg::ActWrite)
                            && (action_q != lsc_pkg::ActDrain);
  assign sts_o.drain      = (action_q == lsc_pkg::ActDrain);
  assign sts_o.issue_last = (idx_q == LastIdx);
  assign sts_o.out_free   = !rsp_valid_q || rsp_ready_i;

  // Age a valid slot other than the target whose rank lies below the limit.
  assign age_we  = cmd_i.update && p_vld_q && p_valid && (p_idx_q != s_q)
                   && ({1'b0, rank_rd_q} < limit_q);
  assign rank_we = age_we || cmd_i.commit;
  assign rank_wa = cmd_i.commit ? s_q : p_idx_q;
  assign rank_wd = cmd_i.commit ? '0 : rank_rd_q + 1'b1;

  // Memories: registered read at the scan index, one write port each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      tag_rd_q  <= tag_mem[idx_q];
      rank_rd_q <= rank_mem[idx_q];
    end
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
    if (cmd_i.commit && miss_q) tag_mem[s_q] <= sector_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= cmd_i.issue;
      if (cmd_i.issue) idx_q <= (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) p_idx_q <= idx_q;
    if (cmd_i.capture) begin
      action_q <= action_i;
      sector_q <= sector_i;
    end
  end

  // Scan accumulators: first hit, lowest free slot, oldest valid slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_fnd_q  <= 1'b0;
      free_fnd_q <= 1'b0;
      old_fnd_q  <= 1'b0;
    end else if (cmd_i.capture) begin
      hit_fnd_q  <= 1'b0;
      free_fnd_q <= 1'b0;
      old_fnd_q  <= 1'b0;
    end else if (cmd_i.scan && p_vld_q) begin
      if (p_valid && (tag_rd_q == sector_q) && !hit_fnd_q) hit_fnd_q <= 1'b1;
      if (!p_valid && !free_fnd_q) free_fnd_q <= 1'b1;
      if (p_valid) old_fnd_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && p_vld_q) begin
      if (p_valid && (tag_rd_q == sector_q) && !hit_fnd_q) begin
        hit_idx_q  <= p_idx_q;
        hit_rank_q <= rank_rd_q;
      end
      if (!p_valid && !free_fnd_q) free_idx_q <= p_idx_q;
      if (p_valid && (!old_fnd_q || (rank_rd_q > old_rank_q))) begin
        old_idx_q  <= p_idx_q;
        old_rank_q <= rank_rd_q;
        old_tag_q  <= tag_rd_q;
      end
    end
  end

  // Decision on the target slot, the aging limit and the result fields.
  always_comb begin
    s_d     = '0;
    limit_d = FullLim;
    res_d   = '0;
    set_vld = 1'b0;
    clr_vld = 1'b0;
    if (sts_o.drain) begin
      if (!old_fnd_q) begin
        res_d.was_empty = 1'b1;
      end else begin
        s_d                    = old_idx_q;
        res_d.writeback_valid  = 1'b1;
        res_d.writeback_sector = old_tag_q;
        clr_vld                = 1'b1;
      end
    end else if (hit_fnd_q) begin
      s_d       = hit_idx_q;
      limit_d   = {1'b0, hit_rank_q};
      res_d.hit = 1'b1;
    end else begin
      res_d.fetch_needed = (action_q == lsc_pkg::ActRead);
      if (free_fnd_q) begin
        s_d     = free_idx_q;
        set_vld = 1'b1;
      end else begin
        s_d                    = old_idx_q;
        res_d.writeback_valid  = 1'b1;
        res_d.writeback_sector = old_tag_q;
      end
    end
    s_ext      = 32'(s_d);
    res_d.slot = s_ext[lsc_pkg::SlotW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      s_q     <= s_d;
      limit_q <= limit_d;
      res_q   <= res_d;
      miss_q  <= !res_d.hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.decide) begin
      if (set_vld) valid_q[s_d] <= 1'b1;
      if (clr_vld) valid_q[s_d] <= 1'b0;
    end
  end

  // Output register: hold the item until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.respond) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) rsp_q <= res_q;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

>>> src/lru_sector_cache_directory.sv
// Top level of the fully associative LRU sector cache directory.
// Usage:
//   req_i carries one item per access: action (read, write or drain) and the
//   disk sector number. rsp_o returns one item per read, write or drain: hit,
//   slot now holding the sector (or freed by a drain), fetch_needed for a read
//   miss, writeback_valid/writeback_sector for an evicted entry and was_empty
//   for a drain of an empty directory. An unknown action is taken and dropped
//   without a result.
// Operation:
//   Items are handled one at a time. One pass over the tag and rank memories
//   finds hit, free and oldest slot, a second read-modify-write pass over the
//   rank memory ages the slots. A drain needs only the first pass. The single
//   read port of each memory reads one slot per cycle.
// Reset: all valid bits clear at once; tag and rank memories are not cleared,
//   and the block takes items right after reset.
// Stall:
//   The result sits in an output register; a stalled receiver holds it there
//   and the block holds the next finished result until the register frees.
module lru_sector_cache_directory #(
  parameter int SLOTS = lsc_pkg::SlotsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lsc_req_if.sink   req_i,
  lsc_rsp_if.source rsp_o
);

  lsc_pkg::ctrl_cmd_t  cmd;
  lsc_pkg::dpath_sts_t sts;
  lsc_pkg::rsp_t       rsp;
  logic                req_ready;
  logic                rsp_valid;

  // Sequencer: steps through the two passes, one slot per cycle.
  lsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: memories, valid bits, LRU bookkeeping, output register.
  lsc_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .action_i    (req_i.action),
    .sector_i    (req_i.sector),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  assign req_i.ready            = req_ready;
  assign rsp_o.valid            = rsp_valid;
  assign rsp_o.hit              = rsp.hit;
  assign rsp_o.slot             = rsp.slot;
  assign rsp_o.fetch_needed     = rsp.fetch_needed;
  assign rsp_o.writeback_valid  = rsp.writeback_valid;
  assign rsp_o.writeback_sector = rsp.writeback_sector;
  assign rsp_o.was_empty        = rsp.was_empty;

endmodule

>>> src/lsc_checker.sv
// Port-level checks of the sector cache directory and their binding.
module lsc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        rsp_hit_i,
  input logic [lsc_pkg::SlotW-1:0]   rsp_slot_i,
  input logic                        rsp_fetch_i,
  input logic                        rsp_wb_valid_i,
  input logic [lsc_pkg::SectorW-1:0] rsp_wb_sector_i,
  input logic                        rsp_empty_i
);

  // A waiting result stays offered until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  // One item at a time: acceptance closes the request side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("second item accepted during processing");

  // A hit neither fetches nor evicts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_hit_i |-> !rsp_fetch_i && !rsp_wb_valid_i && !rsp_empty_i)
    else $error("hit with fetch or eviction");

  // An empty drain reports slot zero and no write-back, and no eviction means no sector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_empty_i || !rsp_wb_valid_i) |->
      rsp_wb_sector_i == '0 && (!rsp_empty_i || (rsp_slot_i == '0 && !rsp_wb_valid_i)))
    else $error("inconsistent empty or write-back fields");

endmodule

bind lru_sector_cache_directory lsc_checker u_lsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_hit_i       (rsp_o.hit),
  .rsp_slot_i      (rsp_o.slot),
  .rsp_fetch_i     (rsp_o.fetch_needed),
  .rsp_wb_valid_i  (rsp_o.writeback_valid),
  .rsp_wb_sector_i (rsp_o.writeback_sector),
  .rsp_empty_i     (rsp_o.was_empty)
);
